// ===== rtl/gnt_pkg.sv =====
`default_nettype none
package gnt_pkg;
    localparam int TABLE_SIZE_DEF = 256;
    localparam int COORD_FRAC_DEF = 24;
    localparam int MAX_OCT        = 8;

    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [1:0] REQ_GRAD = 2'd0;
    localparam logic [1:0] REQ_PERM = 2'd1;
    localparam logic [1:0] REQ_EVAL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 1'b1;

    localparam logic [3:0] OCTAVES_RESET = 4'd7;
    localparam logic       MODE_RESET    = 1'b0;

    localparam logic [16:0] ONE16    = 17'h10000;
    localparam logic [17:0] SMOOTH_K = 18'd196608;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_PERM   = 6'b000010,
        S_SMOOTH = 6'b000100,
        S_CORNER = 6'b001000,
        S_ACCUM  = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    typedef struct packed {
        logic                      en;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mul_req_t;
endpackage
`default_nettype wire

// ===== rtl/gradient_noise_turbulence_top.sv =====
`default_nettype none
// Load item: written to its table on accept, no result.
// Evaluate item: n octaves from accept to result, n = octaves (1 in signed mode);
// each octave does table reads, then smoothstep on 3 axes, then 8 corners,
// all products going one at a time through the single shared multiplier.
// Evaluate items are not overlapped: busy until result is loaded.
// Reset (async, active low) clears control, sets 7 octaves and abs mode; tables stay unknown.
module gradient_noise_turbulence_top #(
    parameter int TABLE_SIZE      = gnt_pkg::TABLE_SIZE_DEF,
    parameter int COORD_FRAC_BITS = gnt_pkg::COORD_FRAC_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [gnt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gnt_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      req_type,
    input  wire logic [7:0]                      table_index,
    input  wire logic signed [15:0]              grad_x,
    input  wire logic signed [15:0]              grad_y,
    input  wire logic signed [15:0]              grad_z,
    input  wire logic [7:0]                      perm_x_entry,
    input  wire logic [7:0]                      perm_y_entry,
    input  wire logic [7:0]                      perm_z_entry,
    input  wire logic [31:0]                     point_x,
    input  wire logic [31:0]                     point_y,
    input  wire logic [31:0]                     point_z,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic signed [18:0]                   noise_value
);
    import gnt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int CRD_W = COORD_FRAC_BITS + IDX_W;
    localparam int FW_W  = COORD_FRAC_BITS + 16;

    state_t state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic [1:0] axis_reg, axis_next;
    logic [2:0] corner_reg, corner_next;
    logic [2:0] oct_reg, oct_next;
    logic [2:0] oct_last_reg, oct_last_next;
    logic [3:0] octaves_reg, octaves_next;
    logic       mode_reg, mode_next;
    logic       out_valid_reg, out_valid_next;
    logic signed [18:0] noise_reg, noise_next;

    logic [CRD_W-1:0] coord_reg [3];
    logic [CRD_W-1:0] coord_next [3];
    logic [7:0]  p0_reg [3];
    logic [7:0]  p0_next [3];
    logic [7:0]  p1_reg [3];
    logic [7:0]  p1_next [3];
    logic [16:0] s_reg [3];
    logic [16:0] s_next [3];
    logic [16:0] w_reg, w_next;
    logic signed [34:0] dot_reg, dot_next;
    logic signed [53:0] osum_reg, osum_next;
    logic signed [55:0] total_reg, total_next;

    logic [IDX_W-1:0] base [3];
    logic [FW_W-1:0]  fw [3];
    logic [15:0]      u [3];
    logic [7:0]       perm_rdata [3];
    logic [IDX_W-1:0] perm_raddr [3];
    logic [7:0]       perm_wdata [3];

    logic        in_acc;
    logic        grad_we, perm_we, perm_re, grad_re;
    logic [IDX_W-1:0] wr_idx, hash;
    logic [47:0] grad_rdata;
    mul_req_t    mreq;
    logic signed [MUL_P_W-1:0] prod;

    logic        di, dj, dk;
    logic [16:0] wx, wy, wz;
    logic signed [16:0] ox, oy, oz;
    logic [15:0] ua;
    logic [3:0]  n_eff;
    logic signed [53:0] osh;
    logic signed [25:0] r26;
    logic signed [26:0] rabs;
    logic signed [18:0] rsat;

    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign wr_idx   = IDX_W'(table_index);
    assign grad_we  = in_acc && (req_type == REQ_GRAD);
    assign perm_we  = in_acc && (req_type == REQ_PERM);
    assign perm_wdata[0] = perm_x_entry;
    assign perm_wdata[1] = perm_y_entry;
    assign perm_wdata[2] = perm_z_entry;

    for (genvar g = 0; g < 3; g++)
    begin : g_axis
        assign base[g] = coord_reg[g][CRD_W-1:COORD_FRAC_BITS];
        assign fw[g]   = {coord_reg[g][COORD_FRAC_BITS-1:0], 16'd0} >> COORD_FRAC_BITS;
        assign u[g]    = fw[g][15:0];
        assign perm_raddr[g] = base[g] + IDX_W'(step_reg[0]);

        gnt_ram #(
            .WIDTH (8),
            .DEPTH (TABLE_SIZE)
        ) u_perm (
            .clk   (clk),
            .we    (perm_we),
            .waddr (wr_idx),
            .wdata (perm_wdata[g]),
            .re    (perm_re),
            .raddr (perm_raddr[g]),
            .rdata (perm_rdata[g])
        );
    end

    gnt_ram #(
        .WIDTH (48),
        .DEPTH (TABLE_SIZE)
    ) u_grad (
        .clk   (clk),
        .we    (grad_we),
        .waddr (wr_idx),
        .wdata ({grad_x, grad_y, grad_z}),
        .re    (grad_re),
        .raddr (hash),
        .rdata (grad_rdata)
    );

    gnt_mul u_mul (
        .clk  (clk),
        .req  (mreq),
        .prod (prod)
    );

    assign di = corner_reg[2];
    assign dj = corner_reg[1];
    assign dk = corner_reg[0];
    assign wx = di ? s_reg[0] : ONE16 - s_reg[0];
    assign wy = dj ? s_reg[1] : ONE16 - s_reg[1];
    assign wz = dk ? s_reg[2] : ONE16 - s_reg[2];
    assign ox = {di, u[0]};
    assign oy = {dj, u[1]};
    assign oz = {dk, u[2]};
    assign hash = IDX_W'((di ? p1_reg[0] : p0_reg[0]) ^ (dj ? p1_reg[1] : p0_reg[1])
                       ^ (dk ? p1_reg[2] : p0_reg[2]));
    assign ua = u[axis_reg];
    assign perm_re = (state_reg == S_PERM) && (step_reg < 3'd2);
    assign grad_re = (state_reg == S_CORNER) && (step_reg == 3'd0);

    assign n_eff = mode_reg ? 4'd1 : ((octaves_reg > 4'(MAX_OCT)) ? 4'(MAX_OCT) : octaves_reg);
    assign osh   = osum_reg >>> oct_reg;
    assign r26   = total_reg[55:30];
    assign rabs  = (!mode_reg && r26[25]) ? -{r26[25], r26} : {r26[25], r26};
    assign rsat  = (rabs > 27'sd262143) ? 19'sd262143 :
                   (rabs < -27'sd262144) ? -19'sd262144 : rabs[18:0];

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        axis_next      = axis_reg;
        corner_next    = corner_reg;
        oct_next       = oct_reg;
        oct_last_next  = oct_last_reg;
        octaves_next   = octaves_reg;
        mode_next      = mode_reg;
        out_valid_next = out_valid_reg && !out_ready;
        noise_next     = noise_reg;
        coord_next     = coord_reg;
        p0_next        = p0_reg;
        p1_next        = p1_reg;
        s_next         = s_reg;
        w_next         = w_reg;
        dot_next       = dot_reg;
        osum_next      = osum_reg;
        total_next     = total_reg;
        mreq.en        = 1'b0;
        mreq.a         = '0;
        mreq.b         = '0;

        if (cfg_we)
        begin
            if (cfg_index == CFG_OCTAVES)
            begin
                octaves_next = cfg_data[3:0];
            end
            else if (cfg_index == CFG_MODE)
            begin
                mode_next = cfg_data[0];
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (req_type == REQ_EVAL))
                begin
                    coord_next[0] = CRD_W'(point_x);
                    coord_next[1] = CRD_W'(point_y);
                    coord_next[2] = CRD_W'(point_z);
                    total_next    = '0;
                    osum_next     = '0;
                    oct_next      = '0;
                    step_next     = '0;
                    if (n_eff == 4'd0)
                    begin
                        oct_last_next = '0;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        oct_last_next = 3'(n_eff - 4'd1);
                        state_next    = S_PERM;
                    end
                end
            end
            S_PERM:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd1)
                begin
                    p0_next = perm_rdata;
                end
                else if (step_reg == 3'd2)
                begin
                    p1_next    = perm_rdata;
                    step_next  = '0;
                    axis_next  = '0;
                    state_next = S_SMOOTH;
                end
            end
            S_SMOOTH:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd0)
                begin
                    mreq.en = 1'b1;
                    mreq.a  = {20'd0, ua};
                    mreq.b  = {2'b0, ua};
                end
                else if (step_reg == 3'd1)
                begin
                    mreq.en = 1'b1;
                    mreq.a  = {18'd0, SMOOTH_K - {1'b0, ua, 1'b0}};
                    mreq.b  = {2'b0, prod[31:16]};
                end
                else
                begin
                    s_next[axis_reg] = prod[32:16];
                    step_next = '0;
                    if (axis_reg == 2'd2)
                    begin
                        corner_next = '0;
                        state_next  = S_CORNER;
                    end
                    else
                    begin
                        axis_next = axis_reg + 2'd1;
                    end
                end
            end
            S_CORNER:
            begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd0:
                    begin
                        mreq.en = 1'b1;
                        mreq.a  = {19'd0, wx};
                        mreq.b  = {1'b0, wy};
                    end
                    3'd1:
                    begin
                        mreq.en = 1'b1;
                        mreq.a  = {19'd0, prod[32:16]};
                        mreq.b  = {1'b0, wz};
                    end
                    3'd2:
                    begin
                        w_next  = prod[32:16];
                        mreq.en = 1'b1;
                        mreq.a  = {{19{ox[16]}}, ox};
                        mreq.b  = {{2{grad_rdata[47]}}, grad_rdata[47:32]};
                    end
                    3'd3:
                    begin
                        dot_next = prod[34:0];
                        mreq.en  = 1'b1;
                        mreq.a   = {{19{oy[16]}}, oy};
                        mreq.b   = {{2{grad_rdata[31]}}, grad_rdata[31:16]};
                    end
                    3'd4:
                    begin
                        dot_next = dot_reg + prod[34:0];
                        mreq.en  = 1'b1;
                        mreq.a   = {{19{oz[16]}}, oz};
                        mreq.b   = {{2{grad_rdata[15]}}, grad_rdata[15:0]};
                    end
                    3'd5:
                    begin
                        dot_next = dot_reg + prod[34:0];
                    end
                    3'd6:
                    begin
                        mreq.en = 1'b1;
                        mreq.a  = {dot_reg[34], dot_reg};
                        mreq.b  = {1'b0, w_reg};
                    end
                    default:
                    begin
                        osum_next = osum_reg + prod;
                        step_next = '0;
                        if (corner_reg == 3'd7)
                        begin
                            state_next = S_ACCUM;
                        end
                        else
                        begin
                            corner_next = corner_reg + 3'd1;
                        end
                    end
                endcase
            end
            S_ACCUM:
            begin
                total_next = total_reg + {{2{osh[53]}}, osh};
                osum_next  = '0;
                step_next  = '0;
                if (oct_reg == oct_last_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    oct_next = oct_reg + 3'd1;
                    for (int a = 0; a < 3; a++)
                    begin
                        coord_next[a] = {coord_reg[a][CRD_W-2:0], 1'b0};
                    end
                    state_next = S_PERM;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    noise_next     = rsat;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            axis_reg      <= '0;
            corner_reg    <= '0;
            oct_reg       <= '0;
            oct_last_reg  <= '0;
            octaves_reg   <= OCTAVES_RESET;
            mode_reg      <= MODE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            axis_reg      <= axis_next;
            corner_reg    <= corner_next;
            oct_reg       <= oct_next;
            oct_last_reg  <= oct_last_next;
            octaves_reg   <= octaves_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        noise_reg <= noise_next;
        coord_reg <= coord_next;
        p0_reg    <= p0_next;
        p1_reg    <= p1_next;
        s_reg     <= s_next;
        w_reg     <= w_next;
        dot_reg   <= dot_next;
        osum_reg  <= osum_next;
        total_reg <= total_next;
    end

    assign out_valid   = out_valid_reg;
    assign noise_value = noise_reg;

`ifndef NO_ASSERTIONS
    a_last_octave_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACCUM && oct_reg == oct_last_reg) |=> state_reg == S_DONE)
        else $error("last octave did not finish the item");
    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !out_ready) |=> state_reg == S_DONE)
        else $error("result dropped while output held");
    a_oct_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> oct_reg <= oct_last_reg)
        else $error("octave counter past last octave");
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PERM || state_reg == S_SMOOTH) |-> step_reg <= 3'd2)
        else $error("step counter out of range");
`endif
endmodule
`default_nettype wire

// ===== rtl/gnt_ram.sv =====
`default_nettype none
module gnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ===== rtl/gnt_mul.sv =====
`default_nettype none
module gnt_mul (
    input  wire logic                               clk,
    input  wire gnt_pkg::mul_req_t                  req,
    output logic signed [gnt_pkg::MUL_P_W-1:0]      prod
);
    import gnt_pkg::*;

    logic signed [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= req.a * req.b;
        end
    end

    assign prod = prod_reg;
endmodule
`default_nettype wire
